[sv/sst_pkg.sv]
// Package for the sparse set table: sizes, codes and word types.
package sst_pkg;

   localparam int KEY_RANGE   = 1024;
   localparam int CAPACITY    = 256;
   localparam int VALUE_WIDTH = 32;
   localparam int KEY_W       = 10;
   localparam int SLOT_W      = 8;
   localparam int CNT_W       = 9;
   localparam int MAP_AW      = $clog2(KEY_RANGE);

   typedef enum logic [1:0] {
      OP_SET      = 2'd0,
      OP_GET      = 2'd1,
      OP_REMOVE   = 2'd2,
      OP_CONTAINS = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_RANGE = 2'd2
   } status_type;

   typedef struct packed {
      op_type                   op;
      logic [KEY_W-1:0]         key;
      logic [VALUE_WIDTH-1:0]   value;
   } req_type;

   typedef struct packed {
      logic                     found;
      logic [VALUE_WIDTH-1:0]   read_value;
      status_type               status;
      logic [CNT_W-1:0]         entry_count;
      logic [SLOT_W-1:0]        slot;
   } rsp_type;

   typedef struct packed {
      logic                     valid;
      logic [SLOT_W-1:0]        slot;
   } map_entry_type;

   typedef struct packed {
      logic [KEY_W-1:0]         key;
      logic [VALUE_WIDTH-1:0]   value;
   } dense_entry_type;

endpackage

[sv/sst_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module sst_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/sparse_set_table.sv]
// Sparse set table: key map plus packed dense store under a small sequencer.
// Sorted mode: each insert or remove is followed by an insertion sort through the one
// dense RAM read port, then a map rebuild from the dense store.
// One word in flight; req_stall stays high until the result is loaded.
// Synchronous reset; after reset a clearing pass over all KEY_RANGE map entries empties the map.
module sparse_set_table
   import sst_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data,
   input  logic    csr_valid,
   output logic    csr_ready,
   input  logic    csr_data
);

   typedef enum logic [14:0] {
      S_CLEAR = 15'h0001,
      S_IDLE  = 15'h0002,
      S_LOOK  = 15'h0004,
      S_GETV  = 15'h0008,
      S_RMV1  = 15'h0010,
      S_RMV2  = 15'h0020,
      S_SRDI  = 15'h0040,
      S_SGETI = 15'h0080,
      S_SCHK  = 15'h0100,
      S_SCMP  = 15'h0200,
      S_RRD   = 15'h0400,
      S_RWR   = 15'h0800,
      S_FIN   = 15'h1000,
      S_DONE  = 15'h2000,
      S_SPARE = 15'h4000
   } state_type;

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              sorted_ff, sorted_in;
   logic [MAP_AW-1:0] clr_ff, clr_in;
   req_type           req_ff, req_in;
   logic [CNT_W-1:0]  i_ff, i_in;
   logic [SLOT_W-1:0] j_ff, j_in;
   dense_entry_type   hold_ff, hold_in;
   rsp_type           res_ff, res_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff, rsp_data_in;

   logic              map_we;
   logic [MAP_AW-1:0] map_wa, map_ra;
   map_entry_type     map_wd, map_q;
   logic              dn_we;
   logic [SLOT_W-1:0] dn_wa, dn_ra;
   dense_entry_type   dn_wd, dn_q;
   logic              present, out_free;

   sst_ram #(.WIDTH($bits(map_entry_type)), .DEPTH(KEY_RANGE)) u_map (
      .clock(clock), .wr_en(map_we), .wr_addr(map_wa), .wr_data(map_wd),
      .rd_addr(map_ra), .rd_data(map_q)
   );

   sst_ram #(.WIDTH($bits(dense_entry_type)), .DEPTH(CAPACITY)) u_dense (
      .clock(clock), .wr_en(dn_we), .wr_addr(dn_wa), .wr_data(dn_wd),
      .rd_addr(dn_ra), .rd_data(dn_q)
   );

   assign present   = map_q.valid && ({1'b0, map_q.slot} < cnt_ff);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      sorted_in    = sorted_ff;
      clr_in       = clr_ff;
      req_in       = req_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      hold_in      = hold_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      map_we       = 1'b0;
      map_wa       = req_ff.key[MAP_AW-1:0];
      map_wd       = '0;
      map_ra       = req_ff.key[MAP_AW-1:0];
      dn_we        = 1'b0;
      dn_wa        = j_ff;
      dn_wd        = hold_ff;
      dn_ra        = '0;

      if (csr_valid && csr_ready) begin
         sorted_in = csr_data;
      end
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_CLEAR: begin
            map_we = 1'b1;
            map_wa = clr_ff;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == MAP_AW'(KEY_RANGE - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               req_in            = req_data;
               map_ra            = req_data.key[MAP_AW-1:0];
               res_in            = '0;
               res_in.status     = ST_OK;
               if ({1'b0, req_data.key} >= (KEY_W + 1)'(KEY_RANGE)) begin
                  res_in.status = ST_RANGE;
                  state_in      = S_DONE;
               end else begin
                  state_in = S_LOOK;
               end
            end
         end
         S_LOOK: begin
            res_in.found = present;
            state_in     = S_DONE;
            case (req_ff.op)
               OP_GET: begin
                  if (present) begin
                     res_in.slot = map_q.slot;
                     dn_ra       = map_q.slot;
                     state_in    = S_GETV;
                  end
               end
               OP_CONTAINS: begin
                  if (present) begin
                     res_in.slot = map_q.slot;
                  end
               end
               OP_SET: begin
                  dn_wd.key   = req_ff.key;
                  dn_wd.value = req_ff.value;
                  if (present) begin
                     dn_we       = 1'b1;
                     dn_wa       = map_q.slot;
                     res_in.slot = map_q.slot;
                  end else if (cnt_ff == CNT_W'(CAPACITY)) begin
                     res_in.status = ST_FULL;
                  end else begin
                     dn_we        = 1'b1;
                     dn_wa        = cnt_ff[SLOT_W-1:0];
                     map_we       = 1'b1;
                     map_wd.valid = 1'b1;
                     map_wd.slot  = cnt_ff[SLOT_W-1:0];
                     cnt_in       = cnt_ff + 1'b1;
                     res_in.slot  = cnt_ff[SLOT_W-1:0];
                     if (sorted_ff) begin
                        i_in     = CNT_W'(1);
                        state_in = S_SRDI;
                     end
                  end
               end
               default: begin
                  if (present) begin
                     j_in     = map_q.slot;
                     dn_ra    = SLOT_W'(cnt_ff - 1'b1);
                     state_in = S_RMV1;
                  end
               end
            endcase
         end
         S_GETV: begin
            res_in.read_value = dn_q.value;
            state_in          = S_DONE;
         end
         S_RMV1: begin
            dn_we        = 1'b1;
            dn_wa        = j_ff;
            dn_wd        = dn_q;
            map_we       = 1'b1;
            map_wa       = dn_q.key[MAP_AW-1:0];
            map_wd.valid = 1'b1;
            map_wd.slot  = j_ff;
            state_in     = S_RMV2;
         end
         S_RMV2: begin
            map_we      = 1'b1;
            cnt_in      = cnt_ff - 1'b1;
            res_in.slot = '0;
            if (sorted_ff) begin
               i_in     = CNT_W'(1);
               state_in = S_SRDI;
            end else begin
               state_in = S_DONE;
            end
         end
         S_SRDI: begin
            if (i_ff >= cnt_ff) begin
               i_in     = '0;
               state_in = S_RRD;
            end else begin
               dn_ra    = i_ff[SLOT_W-1:0];
               state_in = S_SGETI;
            end
         end
         S_SGETI: begin
            hold_in  = dn_q;
            j_in     = i_ff[SLOT_W-1:0];
            state_in = S_SCHK;
         end
         S_SCHK: begin
            if (j_ff == '0) begin
               dn_we    = 1'b1;
               i_in     = i_ff + 1'b1;
               state_in = S_SRDI;
            end else begin
               dn_ra    = j_ff - 1'b1;
               state_in = S_SCMP;
            end
         end
         S_SCMP: begin
            dn_we = 1'b1;
            if (dn_q.key > hold_ff.key) begin
               dn_wd    = dn_q;
               j_in     = j_ff - 1'b1;
               state_in = S_SCHK;
            end else begin
               i_in     = i_ff + 1'b1;
               state_in = S_SRDI;
            end
         end
         S_RRD: begin
            if (i_ff >= cnt_ff) begin
               state_in = (req_ff.op == OP_SET) ? S_FIN : S_DONE;
            end else begin
               dn_ra    = i_ff[SLOT_W-1:0];
               state_in = S_RWR;
            end
         end
         S_RWR: begin
            map_we       = 1'b1;
            map_wa       = dn_q.key[MAP_AW-1:0];
            map_wd.valid = 1'b1;
            map_wd.slot  = i_ff[SLOT_W-1:0];
            i_in         = i_ff + 1'b1;
            state_in     = S_RRD;
         end
         S_FIN: begin
            res_in.slot = map_q.slot;
            state_in    = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in             = res_ff;
               rsp_data_in.entry_count = cnt_ff;
               state_in                = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         cnt_ff       <= '0;
         sorted_ff    <= 1'b0;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         sorted_ff    <= sorted_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff      <= req_in;
      i_ff        <= i_in;
      j_ff        <= j_in;
      hold_ff     <= hold_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

[sv/sst_check.sv]
// Port-level checker for the sparse set table, bound to the top level.
module sst_check
   import sst_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled rsp word changed");

   a_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == ST_FULL |->
         !rsp_data.found && rsp_data.entry_count == CNT_W'(CAPACITY))
      else $error("full status with bad fields");

   a_absent: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.found |-> rsp_data.read_value == '0)
      else $error("read value without hit");

   a_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.entry_count <= CNT_W'(CAPACITY))
      else $error("entry count above capacity");

endmodule

bind sparse_set_table sst_check u_sst_check (
   .clock(clock), .reset(reset), .rsp_valid(rsp_valid),
   .rsp_stall(rsp_stall), .rsp_data(rsp_data)
);

[test/tb_sparse_set_table.sv]
// Testbench for sparse_set_table: directed table plus random words, checked by a local model.
module tb_sparse_set_table;
   import sst_pkg::*;

   localparam int CYCLE_LIMIT = 2000000;

   typedef struct {
      req_type w;
      bit      typed;
      rsp_type r;
   } dir_row_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic    csr_valid = 1'b0;
   logic    csr_ready;
   logic    csr_data = 1'b0;

   sparse_set_table dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // model of the store
   bit                     key_used [KEY_RANGE];
   logic [SLOT_W-1:0]      key_pos [KEY_RANGE];
   logic [KEY_W-1:0]       dense_key [CAPACITY];
   logic [VALUE_WIDTH-1:0] dense_val [CAPACITY];
   int                     entries = 0;
   bit                     sorted_mode = 1'b0;

   rsp_type pending_rsp[$];
   int      errors = 0;
   int      cycles = 0;
   bit      quiet_rx = 1'b0;
   int      stall_left = 0;

   function automatic void sort_store();
      logic [KEY_W-1:0]       k;
      logic [VALUE_WIDTH-1:0] v;
      int                     j;
      for (int i = 1; i < entries; i++) begin
         k = dense_key[i];
         v = dense_val[i];
         j = i;
         while (j > 0 && dense_key[j-1] > k) begin
            dense_key[j] = dense_key[j-1];
            dense_val[j] = dense_val[j-1];
            j--;
         end
         dense_key[j] = k;
         dense_val[j] = v;
      end
      for (int i = 0; i < entries; i++) key_pos[dense_key[i]] = SLOT_W'(i);
   endfunction

   function automatic rsp_type table_apply(req_type w);
      rsp_type           r;
      bit                hit;
      logic [SLOT_W-1:0] s;
      logic [SLOT_W-1:0] last;
      r = '0;
      r.status = ST_OK;
      hit = key_used[w.key];
      r.found = hit;
      case (w.op)
         OP_SET: begin
            if (hit) begin
               dense_val[key_pos[w.key]] = w.value;
            end else if (entries >= CAPACITY) begin
               r.status = ST_FULL;
            end else begin
               dense_key[entries] = w.key;
               dense_val[entries] = w.value;
               key_pos[w.key] = SLOT_W'(entries);
               key_used[w.key] = 1'b1;
               entries++;
               if (sorted_mode) sort_store();
            end
            if (r.status == ST_OK) r.slot = key_pos[w.key];
         end
         OP_GET: begin
            if (hit) begin
               r.slot = key_pos[w.key];
               r.read_value = dense_val[key_pos[w.key]];
            end
         end
         OP_REMOVE: begin
            if (hit) begin
               s = key_pos[w.key];
               last = SLOT_W'(entries - 1);
               dense_key[s] = dense_key[last];
               dense_val[s] = dense_val[last];
               key_pos[dense_key[last]] = s;
               key_used[w.key] = 1'b0;
               key_pos[w.key] = '0;
               entries--;
               if (sorted_mode) sort_store();
            end
         end
         default: begin
            if (hit) r.slot = key_pos[w.key];
         end
      endcase
      r.entry_count = CNT_W'(entries);
      return r;
   endfunction

   function automatic int pick_gap();
      if ($urandom_range(0, 99) < 88) return $urandom_range(0, 3);
      return $urandom_range(12, 60);
   endfunction

   task automatic send_word(req_type w, bit typed, rsp_type r);
      int      gap;
      rsp_type e;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      do @(posedge clock); while (req_stall);
      e = table_apply(w);
      pending_rsp.push_back(typed ? r : e);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_sorted(bit v);
      drain();
      csr_valid <= 1'b1;
      csr_data  <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      sorted_mode = v;
   endtask

   task automatic send_random(int lo, int hi);
      req_type w;
      int      sel;
      w.op = op_type'($urandom_range(0, 3));
      w.key = ($urandom_range(0, 3) == 0) ? KEY_W'($urandom_range(0, KEY_RANGE - 1))
                                          : KEY_W'($urandom_range(lo, hi));
      sel = $urandom_range(0, 7);
      w.value = (sel == 0) ? '0 : (sel == 1) ? '1 : $urandom();
      send_word(w, 1'b0, '0);
   endtask

   task automatic send_sorted_random();
      req_type w;
      w.op = op_type'($urandom_range(0, 3));
      w.key = KEY_W'($urandom_range(0, 15));
      w.value = $urandom();
      send_word(w, 1'b0, '0);
   endtask

   dir_row_type dir_rows [14] = '{
      '{'{OP_GET, 10'd5, 32'h1234_5678}, 1'b1, '{1'b0, 32'd0, ST_OK, 9'd0, 8'd0}},
      '{'{OP_CONTAINS, 10'd1023, 32'd0}, 1'b1, '{1'b0, 32'd0, ST_OK, 9'd0, 8'd0}},
      '{'{OP_REMOVE, 10'd0, 32'd0}, 1'b1, '{1'b0, 32'd0, ST_OK, 9'd0, 8'd0}},
      '{'{OP_SET, 10'd0, 32'd0}, 1'b1, '{1'b0, 32'd0, ST_OK, 9'd1, 8'd0}},
      '{'{OP_SET, 10'd1023, 32'hFFFF_FFFF}, 1'b1, '{1'b0, 32'd0, ST_OK, 9'd2, 8'd1}},
      '{'{OP_GET, 10'd1023, 32'd0}, 1'b1, '{1'b1, 32'hFFFF_FFFF, ST_OK, 9'd2, 8'd1}},
      '{'{OP_GET, 10'd0, 32'hFFFF_FFFF}, 1'b1, '{1'b1, 32'd0, ST_OK, 9'd2, 8'd0}},
      '{'{OP_SET, 10'd0, 32'hA5A5_A5A5}, 1'b1, '{1'b1, 32'd0, ST_OK, 9'd2, 8'd0}},
      '{'{OP_REMOVE, 10'd0, 32'd0}, 1'b1, '{1'b1, 32'd0, ST_OK, 9'd1, 8'd0}},
      '{'{OP_CONTAINS, 10'd1023, 32'd0}, 1'b1, '{1'b1, 32'd0, ST_OK, 9'd1, 8'd0}},
      '{'{OP_SET, 10'd9, 32'h0000_0009}, 1'b0, '0},
      '{'{OP_SET, 10'd3, 32'h8000_0003}, 1'b0, '0},
      '{'{OP_SET, 10'd7, 32'h5A5A_5A5A}, 1'b0, '0},
      '{'{OP_GET, 10'd3, 32'd0}, 1'b0, '0}
   };

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (cycles % 300 == 0) quiet_rx <= ($urandom_range(0, 2) == 0);
      if (reset || quiet_rx) begin
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 3) == 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= pick_gap();
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      rsp_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_rsp.size() == 0) begin
            $display("%0t: unexpected word %p", $time, rsp_data);
            errors++;
         end else begin
            e = pending_rsp.pop_front();
            if (rsp_data.found !== e.found) begin
               $display("%0t: found exp %0d got %0d", $time, e.found, rsp_data.found);
               errors++;
            end
            if (rsp_data.read_value !== e.read_value) begin
               $display("%0t: read_value exp %h got %h", $time, e.read_value,
                        rsp_data.read_value);
               errors++;
            end
            if (rsp_data.status !== e.status) begin
               $display("%0t: status exp %0d got %0d", $time, e.status, rsp_data.status);
               errors++;
            end
            if (rsp_data.entry_count !== e.entry_count) begin
               $display("%0t: entry_count exp %0d got %0d", $time, e.entry_count,
                        rsp_data.entry_count);
               errors++;
            end
            if (rsp_data.slot !== e.slot) begin
               $display("%0t: slot exp %0d got %0d", $time, e.slot, rsp_data.slot);
               errors++;
            end
         end
      end
   end

   initial begin
      req_type w;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_rows[i]) send_word(dir_rows[i].w, dir_rows[i].typed, dir_rows[i].r);

      // dense store is unsorted here; the first change sorts all of it
      write_sorted(1'b1);
      for (int i = 0; i < 150; i++) send_sorted_random();

      write_sorted(1'b0);
      for (int i = 0; i < 150; i++) begin
         send_random(0, 63);
         if (i == 75) drain();
      end

      // fill to capacity, then hit the full store
      while (entries < CAPACITY) begin
         w.op = OP_SET;
         do w.key = KEY_W'($urandom_range(0, KEY_RANGE - 1)); while (key_used[w.key]);
         w.value = $urandom();
         send_word(w, 1'b0, '0);
      end
      for (int i = 0; i < 40; i++) begin
         if (i % 3 == 0) begin
            w.op = OP_SET;
            do w.key = KEY_W'($urandom_range(0, KEY_RANGE - 1)); while (key_used[w.key]);
            w.value = $urandom();
            send_word(w, 1'b0, '0);
         end else begin
            send_random(0, KEY_RANGE - 1);
         end
      end
      for (int i = 0; i < 60; i++) send_random(0, KEY_RANGE - 1);

      drain();
      if (errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
